[hdl/bsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared sizes, constants and types of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int SLOTS     = 128;
   localparam int MAP_BYTES = (SLOTS + 7) / 8;
   localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int BYTE_W    = 8;
   localparam int BIT_W     = 3;
   localparam int IDX_W     = 7;
   localparam int WIDE_W    = 16;

   localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;
   // bits of the last byte that name no slot; treated as busy by the search
   localparam logic [BYTE_W-1:0] PAD_MASK  =
      ((SLOTS % 8) == 0) ? 8'h00 : BYTE_W'(8'hFF << (SLOTS % 8));
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

   localparam logic ACT_BORROW = 1'b0;
   localparam logic ACT_RETURN = 1'b1;

   typedef enum logic [0:0] {
      S_IDLE,
      S_MODIFY
   } state_type;

endpackage : bsa_pkg
`default_nettype wire

[hdl/bsa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bsa_ram
`default_nettype wire

[hdl/bitmap_slot_allocator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// First-fit slot allocator over a byte-packed busy bitmap held in RAM.
// ----------------------------------------------------------------------------
// A borrow transaction (action 0) takes the lowest-numbered free slot, marks
// it busy and returns its index with ok set; with every slot busy it returns
// ok clear and slot 0. A return transaction (action 1) frees the given slot
// and echoes its index with ok set, or with ok clear and no change when the
// index is outside the pool. The busy bitmap lives in a 16 x 8 RAM, one byte
// per eight slots, beside a 16-bit register that marks each full byte. A
// borrow picks the first non-full byte from that summary, reads the byte and
// sets its lowest clear bit. A transaction issues the RAM read when it is
// accepted and modifies and writes back the byte in the modify state. The
// next request is taken in the cycle after the write, so the read always
// sees fresh data. A result that is not yet taken holds the write-back until
// the output frees. Per-byte valid flops, cleared by reset, make the whole
// map read as free straight out of reset with no clearing pass.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic                        req_action,
   input  wire logic [bsa_pkg::IDX_W-1:0]   req_slot_index,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic                        rsp_ok,
   output      logic [bsa_pkg::IDX_W-1:0]   rsp_granted_slot
);

   // --- state ---------------------------------------------------------------
   bsa_pkg::state_type state_ff, state_in;

   logic [bsa_pkg::MAP_BYTES-1:0] full_ff, full_in;    // byte is fully busy
   logic [bsa_pkg::MAP_BYTES-1:0] valid_ff, valid_in;  // byte written since reset

   // captured transaction
   logic                         action_ff, action_in;
   logic [bsa_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [bsa_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic                         miss_ff, miss_in;     // pool full or bad index

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_ok_ff, rsp_ok_in;
   logic [bsa_pkg::IDX_W-1:0]    rsp_slot_ff, rsp_slot_in;

   // --- control -------------------------------------------------------------
   logic accept;
   logic out_free;
   logic finish;
   logic ram_rd_en;
   logic ram_wr_en;

   // --- datapath ------------------------------------------------------------
   logic [bsa_pkg::ADDR_W-1:0]   free_addr;
   logic                         all_full;
   logic [bsa_pkg::WIDE_W-1:0]   idx_wide;
   logic [bsa_pkg::ADDR_W-1:0]   ret_addr;
   logic                         idx_in_range;
   logic [bsa_pkg::ADDR_W-1:0]   rd_addr;
   logic [bsa_pkg::BYTE_W-1:0]   ram_rd_data;
   logic [bsa_pkg::BYTE_W-1:0]   cur_byte;
   logic [bsa_pkg::BYTE_W-1:0]   search_byte;
   logic [bsa_pkg::BIT_W-1:0]    free_bit;
   logic [bsa_pkg::BYTE_W-1:0]   new_byte;
   logic                         new_full;
   logic [bsa_pkg::WIDE_W-1:0]   grant_wide;

   // first non-full byte from the summary
   always_comb begin
      free_addr = '0;
      for (int i = bsa_pkg::MAP_BYTES - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            free_addr = bsa_pkg::ADDR_W'(i);
         end
      end
      all_full = &full_ff;
   end

   assign idx_wide     = bsa_pkg::WIDE_W'(req_slot_index);
   assign ret_addr     = bsa_pkg::ADDR_W'(idx_wide >> bsa_pkg::BIT_W);
   assign idx_in_range = idx_wide < bsa_pkg::WIDE_W'(bsa_pkg::SLOTS);
   assign rd_addr      = (req_action == bsa_pkg::ACT_BORROW) ? free_addr : ret_addr;

   bsa_ram #(
      .WIDTH (bsa_pkg::BYTE_W),
      .DEPTH (bsa_pkg::MAP_BYTES)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (new_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // modify step: never-written bytes read as all free
   always_comb begin
      cur_byte    = valid_ff[addr_ff] ? ram_rd_data : '0;
      search_byte = (addr_ff == bsa_pkg::LAST_ADDR) ? (cur_byte | bsa_pkg::PAD_MASK)
                                                    : cur_byte;
      free_bit = '0;
      for (int k = bsa_pkg::BYTE_W - 1; k >= 0; k--) begin
         if (!search_byte[k]) begin
            free_bit = bsa_pkg::BIT_W'(k);
         end
      end
      if (action_ff == bsa_pkg::ACT_BORROW) begin
         new_byte = cur_byte | (bsa_pkg::BYTE_W'(1) << free_bit);
      end else begin
         new_byte = cur_byte & ~(bsa_pkg::BYTE_W'(1) << idx_ff[bsa_pkg::BIT_W-1:0]);
      end
      new_full = ((addr_ff == bsa_pkg::LAST_ADDR) ? (new_byte | bsa_pkg::PAD_MASK)
                                                  : new_byte) == bsa_pkg::FULL_BYTE;
      grant_wide = (bsa_pkg::WIDE_W'(addr_ff) << bsa_pkg::BIT_W)
                 | bsa_pkg::WIDE_W'(free_bit);
   end

   // --- FSM: next state ------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsa_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = bsa_pkg::S_MODIFY;
            end
         end
         bsa_pkg::S_MODIFY: begin
            if (out_free) begin
               state_in = bsa_pkg::S_IDLE;
            end
         end
         default: state_in = bsa_pkg::S_IDLE;
      endcase
   end

   // --- FSM: outputs --------------------------------------------------------
   // nothing is taken while reset is held
   always_comb begin
      req_ready = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         bsa_pkg::S_IDLE:   req_ready = !reset;
         bsa_pkg::S_MODIFY: finish    = out_free;
         default: begin
            req_ready = 1'b0;
            finish    = 1'b0;
         end
      endcase
   end

   assign accept    = req_valid && req_ready;
   assign ram_rd_en = accept;
   assign ram_wr_en = finish && !miss_ff;

   // --- register next values ------------------------------------------------
   always_comb begin
      action_in = action_ff;
      idx_in    = idx_ff;
      addr_in   = addr_ff;
      miss_in   = miss_ff;
      full_in   = full_ff;
      valid_in  = valid_ff;

      if (accept) begin
         action_in = req_action;
         idx_in    = req_slot_index;
         addr_in   = rd_addr;
         miss_in   = (req_action == bsa_pkg::ACT_BORROW) ? all_full : !idx_in_range;
      end

      if (ram_wr_en) begin
         valid_in[addr_ff] = 1'b1;
         full_in[addr_ff]  = (action_ff == bsa_pkg::ACT_BORROW) ? new_full : 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = !miss_ff;
         if (action_ff == bsa_pkg::ACT_BORROW) begin
            rsp_slot_in = miss_ff ? '0 : grant_wide[bsa_pkg::IDX_W-1:0];
         end else begin
            rsp_slot_in = idx_ff;
         end
      end
   end

   // --- registers -----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsa_pkg::S_IDLE;
         full_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         full_ff      <= full_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff   <= action_in;
      idx_ff      <= idx_in;
      addr_ff     <= addr_in;
      miss_ff     <= miss_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_granted_slot = rsp_slot_ff;

endmodule : bitmap_slot_allocator_top
`default_nettype wire

[tb/tb_bitmap_slot_allocator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_bitmap_slot_allocator_top
// Self-checking bench for the first-fit bitmap slot allocator.
// ----------------------------------------------------------------------------
// Borrow and return transactions are driven over the request channel. Each
// accepted one is run through a local model of the busy map, and the result
// it should give is queued. Every result taken from the block is compared,
// field by field, with the oldest queued result. A short directed part covers
// the corner cases: first grants, out-of-order returns, returning a free slot
// and a full pool. Random runs of mixed borrows and returns then follow under
// three patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_bitmap_slot_allocator_top;

   localparam int CLK_PERIOD  = 12;
   localparam int RESET_TICKS = 11;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic                      ok;
      logic [bsa_pkg::IDX_W-1:0] slot;
   } grant_type;

   // DUT connections; every input is known from time zero
   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   logic                      req_action     = bsa_pkg::ACT_BORROW;
   logic [bsa_pkg::IDX_W-1:0] req_slot_index = '0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   logic                      rsp_ok;
   logic [bsa_pkg::IDX_W-1:0] rsp_granted_slot;

   // local model of the pool and the results still owed by the block
   logic [bsa_pkg::SLOTS-1:0] slot_busy = '0;
   grant_type                 pending_grants[$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;   // chance, per cycle, that the sender holds off
   int recv_stall_pct = 0;  // chance, per cycle, that rsp_ready is low

   bitmap_slot_allocator_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_granted_slot (rsp_granted_slot)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Model of one transaction: first fit for a borrow, clear for a return.
   function automatic grant_type model_allocation(logic action,
                                                  logic [bsa_pkg::IDX_W-1:0] idx);
      grant_type g;
      logic      found;
      g     = '0;
      found = 1'b0;
      if (action == bsa_pkg::ACT_BORROW) begin
         for (int s = 0; s < bsa_pkg::SLOTS; s++) begin
            if (!found && !slot_busy[s]) begin
               found        = 1'b1;
               slot_busy[s] = 1'b1;
               g.ok         = 1'b1;
               g.slot       = bsa_pkg::IDX_W'(s);
            end
         end
      end else begin
         // slot_index cannot exceed the pool at this size, but keep the guard
         if (int'(idx) < bsa_pkg::SLOTS) begin
            slot_busy[idx] = 1'b0;
            g.ok           = 1'b1;
         end
         g.slot = idx;
      end
      return g;
   endfunction

   // Random busy slot, or -1 when the pool is empty.
   function automatic int pick_busy_slot();
      int n;
      int k;
      n = $countones(slot_busy);
      if (n == 0)
         return -1;
      k = $urandom_range(0, n - 1);
      for (int s = 0; s < bsa_pkg::SLOTS; s++) begin
         if (slot_busy[s]) begin
            if (k == 0)
               return s;
            k--;
         end
      end
      return -1;
   endfunction

   // Offers one transaction and returns at the edge that accepts it, with
   // req_valid still high: the caller either sends again or drops valid.
   task automatic send_request(logic action, logic [bsa_pkg::IDX_W-1:0] idx);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_slot_index <= idx;
      do
         @(posedge clock);
      while (!req_ready);
      pending_grants.push_back(model_allocation(action, idx));
   endtask

   // Hold the sender off until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0)
         @(posedge clock);
   endtask

   // ---- directed tests ------------------------------------------------------

   // First grants from an empty pool, holes refilled lowest first.
   task automatic test_first_fit();
      send_request(bsa_pkg::ACT_BORROW, 7'h7F);  // index ignored on borrow
      send_request(bsa_pkg::ACT_BORROW, 7'h00);
      send_request(bsa_pkg::ACT_BORROW, 7'h55);
      send_request(bsa_pkg::ACT_BORROW, 7'h2A);
      send_request(bsa_pkg::ACT_RETURN, 7'd1);
      send_request(bsa_pkg::ACT_RETURN, 7'd0);
      send_request(bsa_pkg::ACT_BORROW, 7'h00);  // slot 0 again
      send_request(bsa_pkg::ACT_BORROW, 7'h7F);  // then slot 1
      send_request(bsa_pkg::ACT_BORROW, 7'h00);  // then slot 4
      drain_results();
   endtask

   // Returning a slot that is already free leaves it free and still says ok.
   task automatic test_return_free_slot();
      send_request(bsa_pkg::ACT_RETURN, 7'd127);
      send_request(bsa_pkg::ACT_RETURN, 7'd100);
      send_request(bsa_pkg::ACT_RETURN, 7'd2);
      send_request(bsa_pkg::ACT_RETURN, 7'd2);   // second return of the same slot
      send_request(bsa_pkg::ACT_BORROW, 7'h00);  // slot 2 is first free again
      send_request(bsa_pkg::ACT_RETURN, 7'd0);
      send_request(bsa_pkg::ACT_RETURN, 7'd0);
   endtask

   // Fill the pool, borrow on a full pool, reopen holes, then empty the pool.
   task automatic test_pool_full();
      while (slot_busy != '1)
         send_request(bsa_pkg::ACT_BORROW, bsa_pkg::IDX_W'($urandom()));
      send_request(bsa_pkg::ACT_BORROW, 7'h00);  // full: ok clear, slot 0
      send_request(bsa_pkg::ACT_BORROW, 7'h7F);
      send_request(bsa_pkg::ACT_RETURN, 7'd127); // top slot
      send_request(bsa_pkg::ACT_BORROW, 7'h00);  // gets 127
      send_request(bsa_pkg::ACT_BORROW, 7'h00);  // full again
      send_request(bsa_pkg::ACT_RETURN, 7'd63);
      send_request(bsa_pkg::ACT_RETURN, 7'd64);
      send_request(bsa_pkg::ACT_BORROW, 7'h00);  // gets 63
      drain_results();
      // empty the pool for the random runs
      while (slot_busy != '0)
         send_request(bsa_pkg::ACT_RETURN, bsa_pkg::IDX_W'(pick_busy_slot()));
      drain_results();
   endtask

   // ---- random traffic ------------------------------------------------------

   // Alternates fill phases (mostly borrows, running into a full pool) with
   // drain phases (mostly returns of busy slots) down to a random low mark.
   task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
      logic                      filling;
      int                        low_mark;
      int                        extra;
      int                        borrow_pct;
      int                        pick;
      logic                      action;
      logic [bsa_pkg::IDX_W-1:0] idx;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      filling  = 1'b1;
      low_mark = 0;
      extra    = 0;
      for (int i = 0; i < n_items; i++) begin
         if (filling && slot_busy == '1) begin
            // sit on a full pool for a few transactions, then drain
            extra++;
            if (extra > $urandom_range(2, 6)) begin
               filling  = 1'b0;
               low_mark = $urandom_range(0, 40);
            end
         end else if (!filling && $countones(slot_busy) <= low_mark) begin
            filling = 1'b1;
            extra   = 0;
         end
         borrow_pct = filling ? 85 : 20;
         idx        = bsa_pkg::IDX_W'($urandom());
         if ($urandom_range(0, 99) < borrow_pct) begin
            action = bsa_pkg::ACT_BORROW;
         end else begin
            action = bsa_pkg::ACT_RETURN;
            pick   = pick_busy_slot();
            if (pick >= 0 && $urandom_range(0, 99) < 85)
               idx = bsa_pkg::IDX_W'(pick);
         end
         send_request(action, idx);
      end
      drain_results();
   endtask

   // ---- receiver and checker ------------------------------------------------

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: result with nothing expected: ok=%0b slot=%0d",
                     $time, rsp_ok, rsp_granted_slot);
            error_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_ok !== want.ok) begin
               $display("%0t: ok mismatch: expected %0b, actual %0b",
                        $time, want.ok, rsp_ok);
               error_count++;
            end
            if (rsp_granted_slot !== want.slot) begin
               $display("%0t: granted_slot mismatch: expected %0d, actual %0d",
                        $time, want.slot, rsp_granted_slot);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---- sequence ------------------------------------------------------------

   initial begin
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      test_first_fit();
      test_return_free_slot();
      test_pool_full();

      // sender mostly busy, receiver stalling hard
      test_random_traffic(125, 19, 64);
      // sender sparse, receiver mostly ready
      test_random_traffic(125, 64, 19);
      // back to back both ways
      test_random_traffic(125, 0, 0);

      req_valid <= 1'b0;
      while (pending_grants.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && pending_grants.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule : tb_bitmap_slot_allocator_top
`default_nettype wire

[filelist.f]
hdl/bsa_pkg.sv
hdl/bsa_ram.sv
hdl/bitmap_slot_allocator_top.sv
tb/tb_bitmap_slot_allocator_top.sv
